[rtl/salc_pkg.sv]
// Package: geometry constants and types for the set-associative LRU cache.
package salc_pkg;
   localparam int NumLines  = 16;
   localparam int LineWords = 4;
   localparam int NumWays   = 2;
   localparam int MemWords  = 65536;
   localparam int SetCount  = (NumLines / NumWays) > 0 ? (NumLines / NumWays) : 1;
   localparam int AddrW     = 16;
   localparam int DataW     = 32;
   localparam int OffW      = (LineWords > 1) ? $clog2(LineWords) : 1;
   localparam int SetW      = (SetCount > 1) ? $clog2(SetCount) : 1;
   localparam int WayW      = (NumWays > 1) ? $clog2(NumWays) : 1;
   localparam int MemW      = $clog2(MemWords);
   localparam int TagW      = AddrW;
   localparam int RankW     = (NumWays > 1) ? $clog2(NumWays) : 1;
   localparam int SlotW     = $clog2(SetCount * NumWays) > 0 ? $clog2(SetCount * NumWays) : 1;
   localparam int WordIdxW  = $clog2(SetCount * NumWays * LineWords);
   localparam int ClrCntW   = MemW + 1;

   localparam logic ReqLoad  = 1'b0;
   localparam logic ReqStore = 1'b1;

   typedef struct packed {
      logic             valid;
      logic [TagW-1:0]  tag;
      logic [RankW-1:0] rank;
   } way_meta_type;

   typedef way_meta_type [NumWays-1:0] set_meta_type;
endpackage

[rtl/set_assoc_lru_cache.sv]
// Top level: set-associative, write-through, write-allocate LRU cache with backing memory.
// A load or store is taken when start is high and busy is low; exactly one result
// beat follows on rsp_* marked by done, and the receiver cannot stall it. After
// reset the block clears its backing memory one word per cycle (MemWords words)
// with busy high; the tag/LRU RAM is cleared in the first cycles of that pass.
// A hit passes through meta read, lookup, data read, read wait and result register,
// then done and the result are registered out. busy drops in that same cycle, so
// the next beat can be taken at the edge that accepts the result; a new request is
// taken only after the last one is done. A miss adds a read and a write step per
// line word, through the backing memory and line RAM, before the data read. Items
// are handled one at a time.
module set_assoc_lru_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [salc_pkg::AddrW-1:0]    req_word_address,
   input  logic signed [salc_pkg::DataW-1:0] req_store_data,
   output logic                          done,
   output logic                          rsp_was_hit,
   output logic signed [salc_pkg::DataW-1:0] rsp_load_data
);
   import salc_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_META, S_LOOKUP, S_FILL_RD, S_FILL_WR, S_DATA_RD, S_DATA_WAIT,
      S_DONE
   } state_type;

   localparam int MetaW = $bits(set_meta_type);

   state_type               state_ff;
   logic [ClrCntW-1:0]      clr_ff;
   logic                    is_store_ff;
   logic [MemW-1:0]         addr_ff;
   logic [DataW-1:0]        data_ff;
   logic                    hit_ff;
   logic [WayW-1:0]         way_ff;
   logic [OffW:0]           cnt_ff;
   set_meta_type            meta_ff;
   logic                    done_ff;
   logic                    rsp_hit_ff;
   logic [DataW-1:0]        rsp_data_ff;

   // address split
   logic [OffW-1:0] offset;
   logic [SetW-1:0] set_idx;
   logic [TagW-1:0] tag;
   always_comb begin
      offset  = OffW'(addr_ff % LineWords);
      set_idx = SetW'((addr_ff / LineWords) % SetCount);
      tag     = TagW'((addr_ff / LineWords) / SetCount);
   end

   // meta (valid, tag, rank) per set in RAM
   logic               meta_we;
   set_meta_type       meta_wdata, meta_rdata;
   logic [SetW-1:0]    meta_raddr, meta_waddr;
   salc_ram #(.Width(MetaW), .Depth(SetCount)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_waddr), .wr_data(meta_wdata),
      .rd_addr(meta_raddr), .rd_data(meta_rdata));

   logic               line_we;
   logic [WordIdxW-1:0] line_waddr, line_raddr;
   logic [DataW-1:0]   line_wdata, line_rdata;
   salc_ram #(.Width(DataW), .Depth(SetCount*NumWays*LineWords)) u_line (
      .clock(clock), .wr_en(line_we), .wr_addr(line_waddr), .wr_data(line_wdata),
      .rd_addr(line_raddr), .rd_data(line_rdata));

   logic               mem_we;
   logic [MemW-1:0]    mem_waddr, mem_raddr;
   logic [DataW-1:0]   mem_wdata, mem_rdata;
   salc_ram #(.Width(DataW), .Depth(MemWords)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata));

   // hit detection and victim choice on registered meta
   logic           hit_c;
   logic [WayW-1:0] hit_way_c, victim_c;
   logic [RankW-1:0] best_rank;
   always_comb begin
      hit_c = 1'b0;
      hit_way_c = '0;
      for (int w = NumWays-1; w >= 0; w--) begin
         if (meta_rdata[w].valid && meta_rdata[w].tag == tag) begin
            hit_c = 1'b1;
            hit_way_c = WayW'(w);
         end
      end
      victim_c = '0;
      best_rank = meta_rdata[0].rank;
      for (int w = 1; w < NumWays; w++) begin
         if (meta_rdata[w].rank > best_rank) begin
            best_rank = meta_rdata[w].rank;
            victim_c = WayW'(w);
         end
      end
      for (int w = NumWays-1; w >= 0; w--) begin
         if (!meta_rdata[w].valid) begin
            victim_c = WayW'(w);
         end
      end
   end

   // LRU touch of the chosen way plus tag install; zeros while clearing
   always_comb begin
      meta_wdata = meta_ff;
      for (int w = 0; w < NumWays; w++) begin
         if (WayW'(w) == way_ff) begin
            meta_wdata[w].rank = '0;
            meta_wdata[w].valid = 1'b1;
            meta_wdata[w].tag = tag;
         end else if (meta_ff[w].rank <= meta_ff[way_ff].rank &&
                      meta_ff[w].rank < RankW'(NumWays-1)) begin
            meta_wdata[w].rank = meta_ff[w].rank + 1'b1;
         end
      end
      if (state_ff == S_CLEAR) begin
         meta_wdata = '0;
      end
   end

   logic [WordIdxW-1:0] slot_base;
   assign slot_base = WordIdxW'((32'(set_idx) * NumWays + 32'(way_ff)) * LineWords);
   logic [MemW-1:0] line_start;
   assign line_start = addr_ff - MemW'(offset);

   always_comb begin
      meta_raddr = set_idx;
      meta_waddr = set_idx;
      meta_we    = (state_ff == S_DATA_RD);
      line_we    = 1'b0;
      line_waddr = slot_base + WordIdxW'(offset);
      line_wdata = data_ff;
      line_raddr = slot_base + WordIdxW'(offset);
      mem_we     = 1'b0;
      mem_waddr  = addr_ff;
      mem_wdata  = data_ff;
      mem_raddr  = line_start + MemW'(cnt_ff);
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff[MemW-1:0];
            mem_wdata = '0;
            meta_we = 1'b1;
            meta_waddr = clr_ff[SetW-1:0];
         end
         S_FILL_WR: begin
            line_we = 1'b1;
            line_waddr = slot_base + WordIdxW'(cnt_ff - 1'b1);
            line_wdata = mem_rdata;
         end
         S_DATA_RD: begin
            line_we = is_store_ff;
            mem_we  = is_store_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ClrCntW'(MemWords-1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               is_store_ff <= req_type;
               addr_ff <= MemW'(req_word_address);
               data_ff <= req_store_data;
               state_ff <= S_META;
            end
            S_META: state_ff <= S_LOOKUP;
            S_LOOKUP: begin
               meta_ff <= meta_rdata;
               hit_ff <= hit_c;
               cnt_ff <= '0;
               if (hit_c) begin
                  way_ff <= hit_way_c;
                  state_ff <= S_DATA_RD;
               end else begin
                  way_ff <= victim_c;
                  state_ff <= S_FILL_RD;
               end
            end
            S_FILL_RD: begin
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= S_FILL_WR;
            end
            S_FILL_WR: begin
               state_ff <= (cnt_ff == (OffW+1)'(LineWords)) ? S_DATA_RD : S_FILL_RD;
            end
            S_DATA_RD: state_ff <= S_DATA_WAIT;
            S_DATA_WAIT: state_ff <= S_DONE;
            S_DONE: begin
               done_ff <= 1'b1;
               rsp_hit_ff <= hit_ff;
               rsp_data_ff <= is_store_ff ? '0 : line_rdata;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign done          = done_ff;
   assign rsp_was_hit   = rsp_hit_ff;
   assign rsp_load_data = rsp_data_ff;
endmodule

[rtl/salc_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module salc_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
